[hdl/fes_pkg.sv]
// Shared types and constants for the field edge scanner.
// Depends on nothing; imported by the top level, the front and the back.
`timescale 1ns / 1ps
`default_nettype none

package fes_pkg;

   // Fixed field widths of the block's ports and sums.
   localparam int PIX_W  = 8;
   localparam int THR_W  = 20;
   localparam int IWID_W = 10;
   localparam int SUM_W  = 21;
   localparam int OCOL_W = 9;
   localparam int OROW_W = 10;

   // Depth of the queue between front and back, and of the result queue.
   localparam int JOB_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(1000);
   localparam logic [IWID_W-1:0] WIDTH_RESET     = IWID_W'(320);

   typedef enum logic [1:0] {
      MARK_TOP   = 2'd0,
      MARK_LEFT  = 2'd1,
      MARK_RIGHT = 2'd2
   } mark_kind_type;

   typedef enum logic {
      CSR_THRESHOLD = 1'b0,
      CSR_WIDTH     = 1'b1
   } csr_index_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_CALC
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_WALK,
      BACK_TOP,
      BACK_LEFT,
      BACK_RIGHT
   } back_state_type;

   // What the front found for one pixel.
   typedef struct packed {
      logic top;
      logic left;
      logic row_end;
   } hits_type;

   // One result item.
   typedef struct packed {
      mark_kind_type       kind;
      logic [OCOL_W-1:0]   column;
      logic [OROW_W-1:0]   row;
      logic                last;
   } mark_type;

endpackage

`default_nettype wire

[hdl/field_edge_scan.sv]
// Field edge scanner, top level. The front does not take a new pixel until it has
// handed the last one's job on; the back handles each pixel and then each of its marks,
// and at row end walks the stored row at one column per cycle before the marks leave.
// Synchronous reset returns the registers to threshold 1000 and width 320 and
// clears position, left sum, fill and queue state; stored column sums past the
// fill count read as zero, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module field_edge_scan
   import fes_pkg::*;
#(
   parameter int MAX_WIDTH = 512,
   parameter int MAX_ROWS  = 1024
) (
   input  logic               clock,
   input  logic               reset,
   // Pixel input, one transfer per pixel in raster order.
   input  logic               req_push,
   input  logic [PIX_W-1:0]   req_pixel,
   input  logic               req_frame_start,
   output logic               req_full,
   // Mark output.
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_mark_kind,
   output logic [OCOL_W-1:0]  rsp_column,
   output logic [OROW_W-1:0]  rsp_row,
   output logic               rsp_last,
   // Register write port.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [THR_W-1:0]   csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int JOB_W = PIX_W + COL_W + ROW_W + $bits(hits_type);

   logic [THR_W-1:0]  threshold_ff, threshold_in;
   logic [IWID_W-1:0] image_width_ff, image_width_in;
   logic [WID_W-1:0]  eff_width;

   logic              job_push, job_full, job_pop, job_empty;
   logic [JOB_W-1:0]  job_wdata, job_rdata;
   logic [PIX_W-1:0]  front_pixel, back_pixel;
   logic [COL_W-1:0]  front_col, back_col;
   logic [ROW_W-1:0]  front_row, back_row;
   hits_type          front_hits, back_hits;

   logic              mark_push, mark_full;
   mark_type          mark, rsp_word;

   // The register port never stalls. Writes must come only while the block is idle
   // (the block does not enforce this), so both parts may read the registers directly.
   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in   = threshold_ff;
      image_width_in = image_width_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_in   = csr_wdata;
            CSR_WIDTH:     image_width_in = csr_wdata[IWID_W-1:0];
            default:       threshold_in   = threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         image_width_ff <= WIDTH_RESET;
      end else begin
         threshold_ff   <= threshold_in;
         image_width_ff <= image_width_in;
      end
   end

   // A width of zero counts as one column, and anything above the row store
   // is held at its depth.
   always_comb begin
      priority if (image_width_ff == '0) begin
         eff_width = WID_W'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         eff_width = WID_W'(MAX_WIDTH);
      end else begin
         eff_width = WID_W'(image_width_ff);
      end
   end

   // Front: column and left sums, one job per pixel.
   fes_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .req_full        (req_full),
      .threshold       (threshold_ff),
      .eff_width       (eff_width),
      .job_push        (job_push),
      .job_full        (job_full),
      .job_pixel       (front_pixel),
      .job_col         (front_col),
      .job_row         (front_row),
      .job_hits        (front_hits)
   );

   // The job queue lets the front keep taking pixels while the back is busy
   // emitting marks or walking a row.
   assign job_wdata = {front_pixel, front_col, front_row, front_hits};
   assign {back_pixel, back_col, back_row, back_hits} = job_rdata;

   fes_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_wdata),
      .full  (job_full),
      .pop   (job_pop),
      .empty (job_empty),
      .rdata (job_rdata)
   );

   // Back: row store, right-hand walk and mark ordering. The walk runs before
   // the pixel's top and left marks leave, so the last flag is known for each.
   fes_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold_ff),
      .eff_width (eff_width),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job_pixel (back_pixel),
      .job_col   (back_col),
      .job_row   (back_row),
      .job_hits  (back_hits),
      .mark_full (mark_full),
      .mark_push (mark_push),
      .mark      (mark)
   );

   // Result queue: waiting marks block the back only once the queue is full.
   fes_fifo #(
      .WIDTH ($bits(mark_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (mark_push),
      .wdata (mark),
      .full  (mark_full),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_word)
   );

   assign rsp_mark_kind = rsp_word.kind;
   assign rsp_column    = rsp_word.column;
   assign rsp_row       = rsp_word.row;
   assign rsp_last      = rsp_word.last;

endmodule

`default_nettype wire

[hdl/fes_fifo.sv]
// Small synchronous first-in first-out queue built from registers.
// Depends on nothing; used for the job queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module fes_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[hdl/fes_front.sv]
// Front of the field edge scanner: takes pixels, keeps column and left sums.
// Depends on fes_pkg; hands one job per pixel to the back through a queue.
`timescale 1ns / 1ps
`default_nettype none

module fes_front
   import fes_pkg::*;
#(
   parameter int MAX_WIDTH = 512,
   parameter int MAX_ROWS  = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic [PIX_W-1:0]                 req_pixel,
   input  logic                             req_frame_start,
   output logic                             req_full,
   input  logic [THR_W-1:0]                 threshold,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_width,
   output logic                             job_push,
   input  logic                             job_full,
   output logic [PIX_W-1:0]                 job_pixel,
   output logic [$clog2(MAX_WIDTH)-1:0]     job_col,
   output logic [$clog2(MAX_ROWS)-1:0]      job_row,
   output hits_type                         job_hits
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_ROWS);

   front_state_type   state_ff, state_in;
   logic [COL_W-1:0]  column_pos_ff, column_pos_in;
   logic [ROW_W-1:0]  row_pos_ff, row_pos_in;
   logic [SUM_W-1:0]  left_sum_ff, left_sum_in;
   logic              left_found_ff, left_found_in;
   // Columns touched since the frame began; entries at and above it read as zero.
   logic [WID_W-1:0]  fill_ff, fill_in;

   logic [PIX_W-1:0]  px_ff;
   logic              col_valid_ff;
   logic [SUM_W:0]    col_mem [MAX_WIDTH];
   logic [SUM_W:0]    col_rd_ff;
   logic [COL_W-1:0]  rd_addr;
   logic              accept;

   logic [SUM_W:0]    entry;
   logic [SUM_W-1:0]  csum_new, lsum_new;
   logic              top_hit, left_hit, row_end;
   logic [SUM_W:0]    col_wdata;

   assign accept  = (state_ff == FRONT_IDLE) && req_push && !job_full;
   assign rd_addr = req_frame_start ? '0 : column_pos_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: if (accept) begin
            state_in = FRONT_CALC;
         end
         FRONT_CALC: state_in = FRONT_IDLE;
         default:    state_in = FRONT_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_full = !((state_ff == FRONT_IDLE) && !job_full);
      job_push = (state_ff == FRONT_CALC);
   end

   always_comb begin
      entry     = col_valid_ff ? col_rd_ff : '0;
      csum_new  = entry[SUM_W-1:0] + SUM_W'(px_ff);
      top_hit   = !entry[SUM_W] && (csum_new > SUM_W'(threshold));
      col_wdata = entry[SUM_W] ? entry : {top_hit, csum_new};
      lsum_new  = left_sum_ff + SUM_W'(px_ff);
      left_hit  = !left_found_ff && (lsum_new >= SUM_W'(threshold));
      row_end   = (WID_W'(column_pos_ff) + WID_W'(1)) >= eff_width;
   end

   assign job_pixel = px_ff;
   assign job_col   = column_pos_ff;
   assign job_row   = row_pos_ff;
   assign job_hits  = '{top: top_hit, left: left_hit, row_end: row_end};

   always_comb begin
      column_pos_in = column_pos_ff;
      row_pos_in    = row_pos_ff;
      left_sum_in   = left_sum_ff;
      left_found_in = left_found_ff;
      fill_in       = fill_ff;
      if (accept && req_frame_start) begin
         column_pos_in = '0;
         row_pos_in    = '0;
         left_sum_in   = '0;
         left_found_in = 1'b0;
         fill_in       = '0;
      end else if (state_ff == FRONT_CALC) begin
         if (WID_W'(column_pos_ff) == fill_ff) begin
            fill_in = fill_ff + WID_W'(1);
         end
         if (row_end) begin
            column_pos_in = '0;
            if (row_pos_ff != ROW_W'(MAX_ROWS - 1)) begin
               row_pos_in = row_pos_ff + ROW_W'(1);
            end
            left_sum_in   = '0;
            left_found_in = 1'b0;
         end else begin
            column_pos_in = column_pos_ff + COL_W'(1);
            if (!left_found_ff) begin
               left_sum_in   = lsum_new;
               left_found_in = left_hit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FRONT_IDLE;
         column_pos_ff <= '0;
         row_pos_ff    <= '0;
         left_sum_ff   <= '0;
         left_found_ff <= 1'b0;
         fill_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         column_pos_ff <= column_pos_in;
         row_pos_ff    <= row_pos_in;
         left_sum_ff   <= left_sum_in;
         left_found_ff <= left_found_in;
         fill_ff       <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff        <= req_pixel;
         col_valid_ff <= !req_frame_start && (WID_W'(column_pos_ff) < fill_ff);
         col_rd_ff    <= col_mem[rd_addr];
      end
      if (state_ff == FRONT_CALC) begin
         col_mem[column_pos_ff] <= col_wdata;
      end
   end

endmodule

`default_nettype wire

[hdl/fes_back.sv]
// Back of the field edge scanner: stores the row, walks it at row end, emits marks.
// Depends on fes_pkg; takes jobs from the front queue, feeds the result queue.
`timescale 1ns / 1ps
`default_nettype none

module fes_back
   import fes_pkg::*;
#(
   parameter int MAX_WIDTH = 512,
   parameter int MAX_ROWS  = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [THR_W-1:0]                 threshold,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_width,
   input  logic                             job_empty,
   output logic                             job_pop,
   input  logic [PIX_W-1:0]                 job_pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0]     job_col,
   input  logic [$clog2(MAX_ROWS)-1:0]      job_row,
   input  hits_type                         job_hits,
   input  logic                             mark_full,
   output logic                             mark_push,
   output mark_type                         mark
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_ROWS);

   back_state_type    state_ff, state_in;
   hits_type          hits_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              found_ff, found_in;
   logic [COL_W-1:0]  rx_ff;

   logic [PIX_W-1:0]  row_mem [MAX_WIDTH];
   logic [PIX_W-1:0]  rd_data_ff;
   logic [COL_W-1:0]  addr_ff;
   logic              issuing_ff, issuing_in;
   logic              dvalid_ff, dvalid_in;
   logic [COL_W-1:0]  dx_ff;
   logic [SUM_W-1:0]  sum_ff, sum_new;
   logic              walk_hit, walk_done, walking;

   logic [COL_W-1:0]  sel_col;
   logic [31:0]       col_wide, row_wide;

   assign walking   = (state_ff == BACK_WALK);
   assign sum_new   = sum_ff + SUM_W'(rd_data_ff);
   assign walk_hit  = walking && dvalid_ff && (sum_new >= SUM_W'(threshold));
   assign walk_done = walking && dvalid_ff && (walk_hit || (dx_ff == '0));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: if (!job_empty) begin
            priority if (job_hits.row_end) state_in = BACK_WALK;
            else if (job_hits.top)         state_in = BACK_TOP;
            else if (job_hits.left)        state_in = BACK_LEFT;
            else                           state_in = BACK_IDLE;
         end
         BACK_WALK: if (walk_done) begin
            priority if (hits_ff.top) state_in = BACK_TOP;
            else if (hits_ff.left)    state_in = BACK_LEFT;
            else if (walk_hit)        state_in = BACK_RIGHT;
            else                      state_in = BACK_IDLE;
         end
         BACK_TOP: if (!mark_full) begin
            priority if (hits_ff.left) state_in = BACK_LEFT;
            else if (found_ff)         state_in = BACK_RIGHT;
            else                       state_in = BACK_IDLE;
         end
         BACK_LEFT: if (!mark_full) begin
            state_in = found_ff ? BACK_RIGHT : BACK_IDLE;
         end
         BACK_RIGHT: if (!mark_full) begin
            state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      job_pop   = (state_ff == BACK_IDLE) && !job_empty;
      mark_push = 1'b0;
      sel_col   = col_ff;
      mark.kind = MARK_TOP;
      mark.last = 1'b1;
      unique case (state_ff)
         BACK_TOP: begin
            mark_push = !mark_full;
            mark.last = !(hits_ff.left || found_ff);
         end
         BACK_LEFT: begin
            mark_push = !mark_full;
            mark.kind = MARK_LEFT;
            mark.last = !found_ff;
         end
         BACK_RIGHT: begin
            mark_push = !mark_full;
            mark.kind = MARK_RIGHT;
            sel_col   = rx_ff;
         end
         default: begin
            mark_push = 1'b0;
         end
      endcase
      col_wide    = 32'(sel_col);
      row_wide    = 32'(row_ff);
      mark.column = col_wide[OCOL_W-1:0];
      mark.row    = row_wide[OROW_W-1:0];
   end

   always_comb begin
      found_in   = found_ff;
      issuing_in = issuing_ff;
      dvalid_in  = walking && issuing_ff;
      if (job_pop) begin
         found_in   = 1'b0;
         issuing_in = 1'b1;
         dvalid_in  = 1'b0;
      end else if (walking) begin
         if (addr_ff == '0) begin
            issuing_in = 1'b0;
         end
         if (walk_hit) begin
            found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BACK_IDLE;
         found_ff   <= 1'b0;
         issuing_ff <= 1'b0;
         dvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         found_ff   <= found_in;
         issuing_ff <= issuing_in;
         dvalid_ff  <= dvalid_in;
      end
   end

   // The walk issues one read a cycle, from the last column downwards; the
   // data of each read is summed in the cycle after it.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         row_mem[job_col] <= job_pixel;
      end
      rd_data_ff <= row_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         hits_ff <= job_hits;
         col_ff  <= job_col;
         row_ff  <= job_row;
         addr_ff <= COL_W'(eff_width - 1'b1);
         sum_ff  <= '0;
      end else if (walking) begin
         if (issuing_ff) begin
            addr_ff <= addr_ff - COL_W'(1);
         end
         if (dvalid_ff) begin
            sum_ff <= sum_new;
         end
         if (walk_hit) begin
            rx_ff <= dx_ff;
         end
      end
      dx_ff <= addr_ff;
   end

endmodule

`default_nettype wire
